// ----- rtl/tlbpc_pkg.sv -----
// shared types and constants for the tlb / page table / cache lookup block
package tlbpc_pkg;

  localparam int TLB_SETS_DEF     = 4;
  localparam int TLB_WAYS_DEF     = 16;
  localparam int PAGE_ENTRIES_DEF = 256;

  localparam int CACHE_SETS = 16;
  localparam int PPN_W      = 8;
  localparam int TAG_W      = 6;
  localparam int VPN_W      = 8;
  localparam int OFF_W      = 6;
  localparam int VA_W       = VPN_W + OFF_W;
  localparam int SLOT_W     = 8;
  localparam int LINE_W     = 4 * 8;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_TLB  = 2'd0,
    CMD_LOAD_PAGE = 2'd1,
    CMD_LOAD_LINE = 2'd2,
    CMD_XLATE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_UNDET = 2'd2
  } status_t;

endpackage

// ----- rtl/tlb_page_table_cache_lookup.sv -----
// top level: tlb, page table and direct-mapped cache lookup on 14-bit virtual addresses
//
// Input beats carry a command in in_tuser and its operands in in_tdata. Load-tlb,
// load-page and load-line beats update the stores and give no output beat. A
// translate beat gives exactly one output beat: out_tuser holds the status (hit,
// cache miss, undetermined), out_tdata the found ppn and the cached byte.
// The block works on one beat at a time. A translate first reads the tlb set row
// and the page table entry, then does the parallel tag compare across the ways of
// the row and the cache line read, and last checks the line tag and loads the
// output register. The output beat shows up when that register is loaded, and
// in_tready comes back then.
// The output register lets the next beat be accepted while a result still waits;
// a translate finishing while the previous result is stalled holds in its last
// step until out_tready frees the register.
// After reset the page table is swept once to clear its present bits, with in_tready
// low until the sweep is done. Tlb fill counts and cache line valid bits clear at once.
module tlb_page_table_cache_lookup #(
  parameter int TLB_SETS     = tlbpc_pkg::TLB_SETS_DEF,
  parameter int TLB_WAYS     = tlbpc_pkg::TLB_WAYS_DEF,
  parameter int PAGE_ENTRIES = tlbpc_pkg::PAGE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot[7:0], tlb_tag_in[13:8], phys_page[21:14], byte_zero[29:22],
  // byte_one[37:30], byte_two[45:38], byte_three[53:46], vaddr[67:54], zero pad
  input  logic [tlbpc_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found_ppn[7:0], data_byte[15:8]
  output logic [tlbpc_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                       out_tuser
);
  import tlbpc_pkg::*;

  localparam int SW = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1;
  localparam int WW = (TLB_WAYS > 1) ? $clog2(TLB_WAYS) : 1;
  localparam int FW = $clog2(TLB_WAYS + 1);
  localparam int PW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int LW = $clog2(CACHE_SETS);
  localparam int TE_W = TAG_W + PPN_W;
  localparam int VPN_N = 1 << VPN_W;

  typedef logic [VPN_N-1:0][TAG_W+SW-1:0] split_tbl_t;

  // vpn -> {tlb tag, tlb set} without a divider
  function automatic split_tbl_t build_split();
    split_tbl_t t;
    int q;
    int r;
    q = 0;
    r = 0;
    for (int i = 0; i < VPN_N; i++) begin
      t[i] = {TAG_W'(q), SW'(r)};
      r = r + 1;
      if (r == TLB_SETS) begin
        r = 0;
        q = q + 1;
      end
    end
    return t;
  endfunction

  localparam split_tbl_t SPLIT_TBL = build_split();

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_TLB,
    S_CACHE
  } state_t;

  // input fields
  logic [SLOT_W-1:0] slot;
  logic [TAG_W-1:0]  tlb_tag_in;
  logic [PPN_W-1:0]  phys_page;
  logic [LINE_W-1:0] line_in;
  logic [VA_W-1:0]   vaddr;
  cmd_t              cmd;

  assign slot       = in_tdata[7:0];
  assign tlb_tag_in = in_tdata[13:8];
  assign phys_page  = in_tdata[21:14];
  assign line_in    = in_tdata[53:22];
  assign vaddr      = in_tdata[67:54];
  assign cmd        = cmd_t'(in_tuser);

  state_t state_r;
  logic [PW-1:0] clr_cnt_r;
  logic [FW-1:0] tlb_fill_r [TLB_SETS];
  logic [CACHE_SETS-1:0] line_valid_r;

  logic [OFF_W-1:0] off_r;
  logic [SW-1:0]    set_r;
  logic [TAG_W-1:0] tag_r;
  logic             pg_range_r;
  logic             known_r;
  logic [PPN_W-1:0] ppn_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]            out_tuser_r;

  // memories
  logic [TLB_WAYS-1:0][TE_W-1:0] tlb_mem [TLB_SETS];
  logic [PPN_W:0]                page_mem [PAGE_ENTRIES];
  logic [PPN_W+LINE_W-1:0]       line_mem [CACHE_SETS];
  logic [TLB_WAYS-1:0][TE_W-1:0] tlb_row_r;
  logic [PPN_W:0]                page_q_r;
  logic [PPN_W+LINE_W-1:0]       line_q_r;
  logic                          line_vld_q_r;

  logic accept;
  logic is_xlate;
  logic [VPN_W-1:0] in_vpn;
  logic [SW-1:0]    in_set;
  logic [TAG_W-1:0] in_tag;
  logic [PW+SLOT_W-1:0] slot_ext;
  logic [PW+VPN_W-1:0]  vpn_ext;
  logic [SW+SLOT_W-1:0] slot_set_ext;
  logic [SW-1:0] ld_set;
  logic [PW-1:0] ld_pidx;
  logic [PW-1:0] rd_pidx;
  logic [LW-1:0] ld_line;
  logic tlb_we;
  logic pg_we;
  logic [PW-1:0] pg_wa;
  logic [PPN_W:0] pg_wd;
  logic line_we;
  logic [FW-1:0] ld_fill;

  logic [FW-1:0]    cur_fill;
  logic             tlb_hit;
  logic [PPN_W-1:0] tlb_ppn;
  logic             known_nxt;
  logic [PPN_W-1:0] ppn_nxt;
  logic [LW-1:0]    rd_line;

  logic             out_free;
  logic             line_match;
  status_t          status_nxt;
  logic [7:0]       data_nxt;
  logic [1:0]       byte_sel;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_xlate  = (cmd == CMD_XLATE);

  assign in_vpn = vaddr[VA_W-1:OFF_W];
  assign {in_tag, in_set} = SPLIT_TBL[in_vpn];

  assign slot_ext     = {{PW{1'b0}}, slot};
  assign vpn_ext      = {{PW{1'b0}}, in_vpn};
  assign slot_set_ext = {{SW{1'b0}}, slot};
  assign ld_set  = slot_set_ext[SW-1:0];
  assign ld_pidx = slot_ext[PW-1:0];
  assign rd_pidx = vpn_ext[PW-1:0];
  assign ld_line = slot[LW-1:0];
  assign ld_fill = tlb_fill_r[ld_set];

  assign tlb_we  = accept && (cmd == CMD_LOAD_TLB) && (32'(slot) < TLB_SETS)
                   && (32'(ld_fill) < TLB_WAYS);
  assign line_we = accept && (cmd == CMD_LOAD_LINE) && (32'(slot) < CACHE_SETS);

  // clearing pass owns the page table write port until it is done
  always_comb begin
    if (state_r == S_CLEAR) begin
      pg_we = 1'b1;
      pg_wa = clr_cnt_r;
      pg_wd = '0;
    end else begin
      pg_we = accept && (cmd == CMD_LOAD_PAGE) && (32'(slot) < PAGE_ENTRIES);
      pg_wa = ld_pidx;
      pg_wd = {1'b1, phys_page};
    end
  end

  always_ff @(posedge clk) begin
    if (tlb_we) begin
      tlb_mem[ld_set][ld_fill[WW-1:0]] <= {tlb_tag_in, phys_page};
    end
    if (accept && is_xlate) begin
      tlb_row_r <= tlb_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      page_mem[pg_wa] <= pg_wd;
    end
    if (accept && is_xlate) begin
      page_q_r <= page_mem[rd_pidx];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[ld_line] <= {phys_page, line_in};
    end
    if (state_r == S_TLB) begin
      line_q_r <= line_mem[rd_line];
    end
  end

  // parallel compare over the row, the highest matching way below the fill wins
  assign cur_fill = tlb_fill_r[set_r];
  always_comb begin
    tlb_hit = 1'b0;
    tlb_ppn = '0;
    for (int w = 0; w < TLB_WAYS; w++) begin
      if ((32'(cur_fill) > w) && (tlb_row_r[w][TE_W-1:PPN_W] == tag_r)) begin
        tlb_hit = 1'b1;
        tlb_ppn = tlb_row_r[w][PPN_W-1:0];
      end
    end
  end

  always_comb begin
    if (tlb_hit) begin
      known_nxt = 1'b1;
      ppn_nxt   = tlb_ppn;
    end else if (pg_range_r && page_q_r[PPN_W]) begin
      known_nxt = 1'b1;
      ppn_nxt   = page_q_r[PPN_W-1:0];
    end else begin
      known_nxt = 1'b0;
      ppn_nxt   = '0;
    end
  end

  assign rd_line  = off_r[OFF_W-1:2];
  assign byte_sel = off_r[1:0];

  assign line_match = line_vld_q_r && (line_q_r[PPN_W+LINE_W-1:LINE_W] == ppn_r);
  always_comb begin
    data_nxt = '0;
    if (!known_r) begin
      status_nxt = ST_UNDET;
    end else if (line_match) begin
      status_nxt = ST_HIT;
      case (byte_sel)
        2'd0:    data_nxt = line_q_r[7:0];
        2'd1:    data_nxt = line_q_r[15:8];
        2'd2:    data_nxt = line_q_r[23:16];
        default: data_nxt = line_q_r[31:24];
      endcase
    end else begin
      status_nxt = ST_MISS;
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      line_valid_r <= '0;
      out_tvalid_r <= 1'b0;
      for (int s = 0; s < TLB_SETS; s++) begin
        tlb_fill_r[s] <= '0;
      end
    end else begin
      // a new result beat takes the register in the cycle the old one leaves
      if ((state_r == S_CACHE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == PAGE_ENTRIES - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (tlb_we) begin
            tlb_fill_r[ld_set] <= ld_fill + 1'b1;
          end
          if (line_we) begin
            line_valid_r[ld_line] <= 1'b1;
          end
          if (accept && is_xlate) begin
            off_r      <= vaddr[OFF_W-1:0];
            set_r      <= in_set;
            tag_r      <= in_tag;
            pg_range_r <= (32'(in_vpn) < PAGE_ENTRIES);
            state_r    <= S_TLB;
          end
        end
        S_TLB: begin
          known_r      <= known_nxt;
          ppn_r        <= ppn_nxt;
          line_vld_q_r <= line_valid_r[rd_line];
          state_r      <= S_CACHE;
        end
        S_CACHE: begin
          if (out_free) begin
            out_tuser_r  <= status_nxt;
            out_tdata_r  <= {data_nxt, ppn_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/tlbpc_checker.sv -----
// port-level checks for the lookup block, bound to the top level
module tlbpc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlbpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser
);
  import tlbpc_pkg::*;

  // stalled result beat stays up
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // stalled result beat keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // undetermined translation carries no ppn and no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_UNDET) |-> (out_tdata == '0))
    else $error("undetermined result with nonzero data");

  // cache miss carries no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_MISS) |-> (out_tdata[15:8] == 8'd0))
    else $error("cache miss with nonzero byte");

  // page table sweep keeps the input closed right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("input opened before page table clear");

endmodule

bind tlb_page_table_cache_lookup tlbpc_checker u_tlbpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- verif/tlbpc_lookup_checker.sv -----
// checker for the lookup block: mirrors the tlb, page table and cache, scores output beats
`timescale 1ns / 100ps
module tlbpc_lookup_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tlbpc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tlbpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                       out_tuser,
  output int                               fail_count,
  output int                               pending,
  output int                               hit_count,
  output int                               miss_count,
  output int                               undet_count
);
  import tlbpc_pkg::*;

  localparam int TLB_SETS     = TLB_SETS_DEF;
  localparam int TLB_WAYS     = TLB_WAYS_DEF;
  localparam int PAGE_ENTRIES = PAGE_ENTRIES_DEF;

  typedef struct packed {
    status_t          status;
    logic [PPN_W-1:0] ppn;
    logic [7:0]       data;
  } xlate_result_t;

  // mirrored stores
  logic [TAG_W-1:0]  tlb_tag_mem [TLB_SETS][TLB_WAYS];
  logic [PPN_W-1:0]  tlb_ppn_mem [TLB_SETS][TLB_WAYS];
  int                tlb_count   [TLB_SETS];
  logic [PPN_W-1:0]  page_ppn    [PAGE_ENTRIES];
  logic              page_valid  [PAGE_ENTRIES];
  logic [PPN_W-1:0]  line_tag    [CACHE_SETS];
  logic              line_ok     [CACHE_SETS];
  logic [LINE_W-1:0] line_data   [CACHE_SETS];

  xlate_result_t expected_xlates[$];
  int mismatch_tally, hits, misses, undets;

  // input beat operands
  logic [SLOT_W-1:0] f_slot;
  logic [TAG_W-1:0]  f_tag;
  logic [PPN_W-1:0]  f_ppn;
  logic [LINE_W-1:0] f_bytes;
  logic [VA_W-1:0]   f_vaddr;

  assign f_slot  = in_tdata[7:0];
  assign f_tag   = in_tdata[13:8];
  assign f_ppn   = in_tdata[21:14];
  assign f_bytes = in_tdata[53:22];
  assign f_vaddr = in_tdata[67:54];

  function automatic xlate_result_t translate_va(logic [VA_W-1:0] va);
    int vpn;
    int set_idx;
    int line_idx;
    logic [TAG_W-1:0] vtag;
    logic known;
    xlate_result_t r;
    vpn      = va[VA_W-1:OFF_W];
    set_idx  = vpn % TLB_SETS;
    vtag     = TAG_W'(vpn / TLB_SETS);
    known    = 1'b0;
    r.status = ST_UNDET;
    r.ppn    = '0;
    r.data   = '0;
    // later ways overwrite earlier matches
    for (int w = 0; w < tlb_count[set_idx]; w++) begin
      if (tlb_tag_mem[set_idx][w] == vtag) begin
        r.ppn = tlb_ppn_mem[set_idx][w];
        known = 1'b1;
      end
    end
    if (!known && vpn < PAGE_ENTRIES && page_valid[vpn]) begin
      r.ppn = page_ppn[vpn];
      known = 1'b1;
    end
    if (known) begin
      line_idx = va[5:2];
      if (line_ok[line_idx] && line_tag[line_idx] == r.ppn) begin
        r.status = ST_HIT;
        r.data   = line_data[line_idx][8*va[1:0] +: 8];
      end else begin
        r.status = ST_MISS;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : score
    xlate_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < TLB_SETS; s++) tlb_count[s] = 0;
      for (int p = 0; p < PAGE_ENTRIES; p++) page_valid[p] = 1'b0;
      for (int l = 0; l < CACHE_SETS; l++) line_ok[l] = 1'b0;
      expected_xlates.delete();
      mismatch_tally = 0;
      hits   = 0;
      misses = 0;
      undets = 0;
    end else begin
      // retire the result beat before queueing a new translate
      if (out_tvalid && out_tready) begin
        if (expected_xlates.size() == 0) begin
          if (mismatch_tally < 10)
            $display("%0t: result beat with nothing expected: status %0d ppn %h byte %h",
                     $time, out_tuser, out_tdata[7:0], out_tdata[15:8]);
          mismatch_tally++;
        end else begin
          want = expected_xlates.pop_front();
          if (out_tuser !== want.status || out_tdata[7:0] !== want.ppn ||
              out_tdata[15:8] !== want.data) begin
            if (mismatch_tally < 10)
              $display("%0t: mismatch: expected status %0d ppn %h byte %h, got %0d %h %h",
                       $time, want.status, want.ppn, want.data,
                       out_tuser, out_tdata[7:0], out_tdata[15:8]);
            mismatch_tally++;
          end
          case (want.status)
            ST_HIT:  hits++;
            ST_MISS: misses++;
            default: undets++;
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        case (cmd_t'(in_tuser))
          CMD_LOAD_TLB: begin
            // full sets drop the load
            if (f_slot < TLB_SETS && tlb_count[f_slot] < TLB_WAYS) begin
              tlb_tag_mem[f_slot][tlb_count[f_slot]] = f_tag;
              tlb_ppn_mem[f_slot][tlb_count[f_slot]] = f_ppn;
              tlb_count[f_slot]++;
            end
          end
          CMD_LOAD_PAGE: begin
            if (f_slot < PAGE_ENTRIES) begin
              page_ppn[f_slot]   = f_ppn;
              page_valid[f_slot] = 1'b1;
            end
          end
          CMD_LOAD_LINE: begin
            if (f_slot < CACHE_SETS) begin
              line_tag[f_slot]  = f_ppn;
              line_data[f_slot] = f_bytes;
              line_ok[f_slot]   = 1'b1;
            end
          end
          default: expected_xlates.push_back(translate_va(f_vaddr));
        endcase
      end
    end
    fail_count  <= mismatch_tally;
    pending     <= expected_xlates.size();
    hit_count   <= hits;
    miss_count  <= misses;
    undet_count <= undets;
  end

endmodule

// ----- verif/tlb_page_table_cache_lookup_tb.sv -----
// testbench top: drives load and translate beats into the lookup block and gives the verdict
`timescale 1ns / 100ps
module tlb_page_table_cache_lookup_tb;
  import tlbpc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 800;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = CMD_LOAD_TLB;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  int fail_count, pending, hit_count, miss_count, undet_count;
  bit bursty        = 1'b1;
  int idle_cycles   = 0;
  int kept_loads    = 0;
  int ignored_loads = 0;
  int xlates_sent   = 0;
  int tlb_kept [TLB_SETS_DEF];
  logic [VPN_W-1:0] mapped_vpns [$];

  initial begin
    forever #5 clk = ~clk;
  end

  tlb_page_table_cache_lookup uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tlbpc_lookup_checker lookup_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .pending     (pending),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .undet_count (undet_count)
  );

  always @(posedge clk) begin
    out_tready <= !bursty || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ppns and line tags mostly from a few values so that tags often match
  function automatic logic [7:0] pick_ppn();
    case ($urandom_range(4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hA5;
      3:       return 8'h3C;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_beat(cmd_t cmd, logic [7:0] slot, logic [5:0] tag, logic [7:0] pp,
                           logic [31:0] bytes, logic [13:0] va);
    while (bursty && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, va, bytes, pp, tag, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // track what the beat did, only to steer later stimulus
    case (cmd)
      CMD_LOAD_TLB: begin
        if (slot < TLB_SETS_DEF && tlb_kept[slot] < TLB_WAYS_DEF) begin
          tlb_kept[slot]++;
          kept_loads++;
          mapped_vpns.push_back({tag, slot[1:0]});
        end else begin
          ignored_loads++;
        end
      end
      CMD_LOAD_PAGE: begin
        kept_loads++;
        mapped_vpns.push_back(slot);
      end
      CMD_LOAD_LINE: begin
        if (slot < CACHE_SETS) kept_loads++;
        else ignored_loads++;
      end
      default: xlates_sent++;
    endcase
  endtask

  initial begin : stimulus
    int start_count;
    int done;
    int pick;
    logic [7:0] vpn;
    logic [7:0] slot;
    logic [13:0] va;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty stores: both address extremes are undetermined
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h0000);
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h3FFF);
    // page table fallback before the line is loaded gives a cache miss
    send_beat(CMD_LOAD_PAGE, 8'hFF, 6'($urandom), 8'hA5, $urandom, 14'($urandom));
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h3FFF);
    send_beat(CMD_LOAD_LINE, 8'd15, 6'($urandom), 8'hA5, 32'hDEADBEEF, 14'($urandom));
    for (int b = 0; b < 4; b++)
      send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom,
                {8'hFF, 4'hF, 2'(b)});
    // tlb entry overrides the page table, then a later match wins
    send_beat(CMD_LOAD_TLB, 8'd3, 6'h3F, 8'h00, $urandom, 14'($urandom));
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h3FFF);
    send_beat(CMD_LOAD_TLB, 8'd3, 6'h3F, 8'hA5, $urandom, 14'($urandom));
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h3FFD);
    // out of range slots must not alias onto set 0 or line 0
    send_beat(CMD_LOAD_TLB, 8'd4, 6'h00, 8'hFF, $urandom, 14'($urandom));
    send_beat(CMD_LOAD_TLB, 8'hFF, 6'h00, 8'hFF, $urandom, 14'($urandom));
    send_beat(CMD_LOAD_LINE, 8'd16, 6'($urandom), 8'h00, $urandom, 14'($urandom));
    send_beat(CMD_LOAD_LINE, 8'hFF, 6'($urandom), 8'h00, $urandom, 14'($urandom));
    send_beat(CMD_LOAD_PAGE, 8'h00, 6'($urandom), 8'h00, $urandom, 14'($urandom));
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h0000);
    send_beat(CMD_LOAD_LINE, 8'd0, 6'($urandom), 8'h00, 32'h00FF00FF, 14'($urandom));
    send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, 14'h0002);

    start_count = kept_loads + ignored_loads + xlates_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      // a long stretch with both sides at full rate
      bursty <= !(done >= 300 && done < 450);
      pick = $urandom_range(99);
      if (pick < 20) begin
        if ($urandom_range(9) == 0) begin
          send_beat(CMD_LOAD_TLB, 8'($urandom), 6'($urandom), pick_ppn(), $urandom,
                    14'($urandom));
        end else begin
          vpn = 8'($urandom);
          send_beat(CMD_LOAD_TLB, {6'b0, vpn[1:0]}, vpn[7:2], pick_ppn(), $urandom,
                    14'($urandom));
        end
      end else if (pick < 40) begin
        send_beat(CMD_LOAD_PAGE, 8'($urandom), 6'($urandom), pick_ppn(), $urandom,
                  14'($urandom));
      end else if (pick < 60) begin
        slot = ($urandom_range(6) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        send_beat(CMD_LOAD_LINE, slot, 6'($urandom), pick_ppn(), $urandom, 14'($urandom));
      end else begin
        if (mapped_vpns.size() != 0 && $urandom_range(3) != 0)
          va = {mapped_vpns[$urandom_range(mapped_vpns.size() - 1)], 6'($urandom)};
        else
          va = 14'($urandom);
        send_beat(CMD_XLATE, 8'($urandom), 6'($urandom), 8'($urandom), $urandom, va);
      end
      done = kept_loads + ignored_loads + xlates_sent - start_count;
    end
    in_tvalid <= 1'b0;
    bursty    <= 1'b1;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d translates and %0d stored loads, %0d loads dropped or ignored",
             xlates_sent, kept_loads, ignored_loads);
    $display("translate outcomes: %0d hits, %0d cache misses, %0d undetermined",
             hit_count, miss_count, undet_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
